### hw/rtl/brle_pkg.sv
package brle_pkg;

  // Internal column and row counters carry one bit above the coordinate range
  localparam int unsigned CNT_W = 17;

  localparam logic [31:0] BLACK_RGBA = 32'h0000_00FF;

  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_PALETTE = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] KIND_SPAN    = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_TRUNC   = 2'd2;
  localparam logic [1:0] KIND_CORRUPT = 2'd3;

  localparam logic [2:0] CFG_RLE4_MODE     = 3'd0;
  localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd1;
  localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd2;
  localparam logic [2:0] CFG_TOP_DOWN      = 3'd3;
  localparam logic [2:0] CFG_PALETTE_COUNT = 3'd4;

  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_SECOND = 3'd1,
    PH_DX     = 3'd2,
    PH_DY     = 3'd3,
    PH_ABS    = 3'd4,
    PH_PAD    = 3'd5
  } phase_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [7:0]  entry_index;
    logic [31:0] entry_color;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] start_col;
    logic [15:0] dest_row;
    logic [7:0]  span_len;
    logic [31:0] color_even;
    logic [31:0] color_odd;
  } out_rsp_t;

  typedef struct packed {
    logic        rle4_mode;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        top_down;
    logic [8:0]  palette_count;
  } cfg_t;

  // Results caused by one request, handed from the parser to the output stage
  typedef struct packed {
    logic        span_vld;
    logic        term_vld;
    logic [1:0]  term_kind;
    logic [15:0] col;
    logic [15:0] row;
    logic [7:0]  len;
    logic        even_ok;
    logic        odd_ok;
  } stage_t;

endpackage

### hw/rtl/brle_palette_ram.sv
module brle_palette_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [31:0]   rdata_a_o,
  output logic [31:0]   rdata_b_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_a_q;
  logic [31:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read so a stalled span keeps its colors
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### hw/rtl/brle_parser.sv
module brle_parser #(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned COORD_BITS    = 16,
  parameter int unsigned OVERRUN_SLACK = 4096,
  parameter int unsigned AW            = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  brle_pkg::in_req_t req_i,
  input  brle_pkg::cfg_t    cfg_i,
  output brle_pkg::stage_t  stage_o,
  output logic              pal_we_o,
  output logic [AW-1:0]     pal_waddr_o,
  output logic [31:0]       pal_wdata_o,
  output logic              pal_re_o,
  output logic [AW-1:0]     pal_raddr_a_o,
  output logic [AW-1:0]     pal_raddr_b_o
);

  localparam int unsigned CW = brle_pkg::CNT_W;
  localparam logic [15:0] COORD_MASK = 16'((32'd1 << COORD_BITS) - 32'd1);
  localparam logic [8:0]  DEPTH_LIM  = 9'(PALETTE_DEPTH);
  localparam logic [CW-1:0] SLACK    = CW'(OVERRUN_SLACK);

  brle_pkg::phase_e phase_q, phase_d;
  logic [7:0]    first_q, first_d;
  logic [7:0]    total_q, total_d;
  logic [7:0]    seen_q, seen_d;
  logic [7:0]    dx_q, dx_d;
  logic [CW-1:0] col_q, col_d;
  logic [CW-1:0] row_q, row_d;
  logic          finished_q, finished_d;

  logic [7:0]    d;
  logic          last;
  logic          data_ok;
  logic          restart;
  logic          eol;
  logic          row_oor;
  logic          abs_final;
  logic          abs_pad;
  logic [8:0]    abs_rem;
  logic [7:0]    abs_cnt;
  logic [7:0]    tot4;
  logic [7:0]    col_add;
  logic [7:0]    row_add;
  logic [CW-1:0] col_sum;
  logic [CW-1:0] col_new;
  logic [CW-1:0] row_new;
  logic [CW-1:0] col_lim;
  logic          overrun;
  logic          pe_done;
  logic [7:0]    even_idx;
  logic [7:0]    odd_idx;
  logic [15:0]   room;
  logic [15:0]   row_dst;

  logic          span_req;
  logic [7:0]    span_cnt;
  logic          pend;
  logic          fin;
  logic [1:0]    fin_kind;

  assign d       = req_i.data_byte;
  assign last    = req_i.last_byte;
  assign data_ok = accept_i && (req_i.op == brle_pkg::OP_DATA) && !finished_q;
  assign restart = accept_i && (req_i.op == brle_pkg::OP_RESTART);

  assign eol     = (phase_q == brle_pkg::PH_SECOND) && (first_q == 8'd0) && (d == brle_pkg::ESC_EOL);
  assign row_oor = row_q >= {1'b0, cfg_i.image_height};

  assign abs_final = ({1'b0, seen_q} + 9'd1) >= {1'b0, total_q};
  assign abs_pad   = total_q[0];
  assign abs_rem   = {1'b0, first_q} - {seen_q, 1'b0};
  assign abs_cnt   = cfg_i.rle4_mode ? ((abs_rem > 9'd2) ? 8'd2 : abs_rem[7:0]) : 8'd1;
  assign tot4      = 8'(({1'b0, d} + 9'd1) >> 1);

  always_comb begin
    unique case (phase_q)
      brle_pkg::PH_SECOND: col_add = first_q;
      brle_pkg::PH_DY:     col_add = dx_q;
      brle_pkg::PH_ABS:    col_add = abs_cnt;
      default:             col_add = 8'd0;
    endcase
  end

  assign row_add = (phase_q == brle_pkg::PH_DY) ? d : (eol ? 8'd1 : 8'd0);
  assign col_sum = col_q + CW'(col_add);
  assign col_new = eol ? '0 : col_sum;
  assign row_new = row_q + CW'(row_add);
  assign col_lim = {1'b0, cfg_i.image_width} + SLACK;
  assign overrun = col_new > col_lim;
  assign pe_done = (row_new >= {1'b0, cfg_i.image_height}) || last;

  // Result decode for one data byte
  always_comb begin
    span_req = 1'b0;
    span_cnt = 8'd0;
    pend     = 1'b0;
    fin      = 1'b0;
    fin_kind = brle_pkg::KIND_DONE;
    if (data_ok) begin
      unique case (phase_q)
        brle_pkg::PH_FIRST: begin
          if (row_oor || last) begin
            fin = 1'b1;
          end
        end
        brle_pkg::PH_SECOND: begin
          if (first_q != 8'd0) begin
            span_req = 1'b1;
            span_cnt = first_q;
            pend     = 1'b1;
          end else if (d == brle_pkg::ESC_EOL) begin
            pend = 1'b1;
          end else if (d == brle_pkg::ESC_EOB) begin
            fin = 1'b1;
          end else if (last) begin
            fin      = 1'b1;
            fin_kind = brle_pkg::KIND_TRUNC;
          end
        end
        brle_pkg::PH_DX: begin
          if (last) begin
            fin      = 1'b1;
            fin_kind = brle_pkg::KIND_TRUNC;
          end
        end
        brle_pkg::PH_DY: begin
          pend = 1'b1;
        end
        brle_pkg::PH_ABS: begin
          if (last && (!abs_final || abs_pad)) begin
            fin      = 1'b1;
            fin_kind = brle_pkg::KIND_TRUNC;
          end else begin
            span_req = 1'b1;
            span_cnt = abs_cnt;
            pend     = abs_final && !abs_pad;
          end
        end
        default: begin
          pend = 1'b1;
        end
      endcase
      if (pend) begin
        if (overrun) begin
          fin      = 1'b1;
          fin_kind = brle_pkg::KIND_CORRUPT;
        end else if (pe_done) begin
          fin = 1'b1;
        end
      end
    end
  end

  // Next parse state
  always_comb begin
    phase_d    = phase_q;
    first_d    = first_q;
    total_d    = total_q;
    seen_d     = seen_q;
    dx_d       = dx_q;
    col_d      = col_q;
    row_d      = row_q;
    finished_d = finished_q;
    if (restart) begin
      phase_d    = brle_pkg::PH_FIRST;
      first_d    = 8'd0;
      total_d    = 8'd0;
      seen_d     = 8'd0;
      dx_d       = 8'd0;
      col_d      = '0;
      row_d      = '0;
      finished_d = 1'b0;
    end else if (data_ok) begin
      col_d = col_new;
      row_d = row_new;
      unique case (phase_q)
        brle_pkg::PH_FIRST: begin
          first_d = d;
          phase_d = brle_pkg::PH_SECOND;
        end
        brle_pkg::PH_SECOND: begin
          phase_d = brle_pkg::PH_FIRST;
          if (first_q == 8'd0 && d == brle_pkg::ESC_DELTA) begin
            phase_d = brle_pkg::PH_DX;
          end else if (first_q == 8'd0 && d > brle_pkg::ESC_DELTA) begin
            first_d = d;
            total_d = cfg_i.rle4_mode ? tot4 : d;
            seen_d  = 8'd0;
            phase_d = brle_pkg::PH_ABS;
          end
        end
        brle_pkg::PH_DX: begin
          dx_d    = d;
          phase_d = brle_pkg::PH_DY;
        end
        brle_pkg::PH_DY: begin
          phase_d = brle_pkg::PH_FIRST;
        end
        brle_pkg::PH_ABS: begin
          seen_d = seen_q + 8'd1;
          if (abs_final) begin
            phase_d = abs_pad ? brle_pkg::PH_PAD : brle_pkg::PH_FIRST;
          end
        end
        default: begin
          phase_d = brle_pkg::PH_FIRST;
        end
      endcase
      if (fin) begin
        phase_d    = brle_pkg::PH_FIRST;
        finished_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= brle_pkg::PH_FIRST;
      first_q    <= 8'd0;
      total_q    <= 8'd0;
      seen_q     <= 8'd0;
      dx_q       <= 8'd0;
      col_q      <= '0;
      row_q      <= '0;
      finished_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      first_q    <= first_d;
      total_q    <= total_d;
      seen_q     <= seen_d;
      dx_q       <= dx_d;
      col_q      <= col_d;
      row_q      <= row_d;
      finished_q <= finished_d;
    end
  end

  // Span clipping and row placement
  assign room    = cfg_i.image_width - col_q[15:0];
  assign row_dst = cfg_i.top_down ? row_q[15:0] : (cfg_i.image_height - 16'd1 - row_q[15:0]);

  assign even_idx = cfg_i.rle4_mode ? {4'd0, d[7:4]} : d;
  assign odd_idx  = cfg_i.rle4_mode ? {4'd0, d[3:0]} : d;

  always_comb begin
    stage_o           = '0;
    stage_o.span_vld  = span_req && !fin_trunc_block() && !row_oor
                        && (col_q < {1'b0, cfg_i.image_width}) && (span_cnt != 8'd0);
    stage_o.term_vld  = fin;
    stage_o.term_kind = fin_kind;
    stage_o.col       = col_q[15:0] & COORD_MASK;
    stage_o.row       = row_dst & COORD_MASK;
    stage_o.len       = (room < {8'd0, span_cnt}) ? room[7:0] : span_cnt;
    stage_o.even_ok   = ({1'b0, even_idx} < cfg_i.palette_count) && ({1'b0, even_idx} < DEPTH_LIM);
    stage_o.odd_ok    = ({1'b0, odd_idx} < cfg_i.palette_count) && ({1'b0, odd_idx} < DEPTH_LIM);
  end

  // A truncation never comes with a span; keep the span decode independent of it
  function automatic logic fin_trunc_block();
    return 1'b0;
  endfunction

  assign pal_we_o      = accept_i && (req_i.op == brle_pkg::OP_PALETTE)
                         && ({1'b0, req_i.entry_index} < DEPTH_LIM);
  assign pal_waddr_o   = req_i.entry_index[AW-1:0];
  assign pal_wdata_o   = req_i.entry_color;
  assign pal_re_o      = data_ok;
  assign pal_raddr_a_o = even_idx[AW-1:0];
  assign pal_raddr_b_o = odd_idx[AW-1:0];

  finished_phase_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> (phase_q == brle_pkg::PH_FIRST))
    else $error("finished decoder left in mid-pair phase");

  term_finishes_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (data_ok && fin) |=> finished_q)
    else $error("terminal result did not stop the decoder");

  trunc_no_span_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && fin_kind == brle_pkg::KIND_TRUNC) |-> !span_req)
    else $error("truncated request produced pixels");

endmodule

### hw/rtl/brle_out_stage.sv
module brle_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  brle_pkg::stage_t   stage_i,
  input  logic [31:0]        rdata_a_i,
  input  logic [31:0]        rdata_b_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output brle_pkg::out_rsp_t out_rsp_o
);

  brle_pkg::stage_t   info_q;
  logic               span_pend_q;
  logic               term_pend_q;
  logic               out_vld_q;
  brle_pkg::out_rsp_t out_q;

  logic               oreg_free;
  logic               take_span;
  logic               take_term;
  brle_pkg::out_rsp_t span_rsp;
  brle_pkg::out_rsp_t term_rsp;

  assign oreg_free = !out_vld_q || out_ready_i;

  always_comb begin
    take_span = 1'b0;
    take_term = 1'b0;
    priority if (oreg_free && span_pend_q) begin
      take_span = 1'b1;
    end else if (oreg_free && term_pend_q) begin
      take_term = 1'b1;
    end else begin
      take_span = 1'b0;
    end
  end

  // Take a new request when none is held, or once the held one drains this cycle
  assign ready_o = !(span_pend_q || term_pend_q)
                   || (oreg_free && !(span_pend_q && term_pend_q));

  always_comb begin
    span_rsp            = '0;
    span_rsp.kind       = brle_pkg::KIND_SPAN;
    span_rsp.start_col  = info_q.col;
    span_rsp.dest_row   = info_q.row;
    span_rsp.span_len   = info_q.len;
    span_rsp.color_even = info_q.even_ok ? rdata_a_i : brle_pkg::BLACK_RGBA;
    span_rsp.color_odd  = info_q.odd_ok ? rdata_b_i : brle_pkg::BLACK_RGBA;
    term_rsp            = '0;
    term_rsp.kind       = info_q.term_kind;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_pend_q <= 1'b0;
      term_pend_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (take_span) begin
        span_pend_q <= 1'b0;
      end
      if (take_term) begin
        term_pend_q <= 1'b0;
      end
      if (load_i) begin
        span_pend_q <= stage_i.span_vld;
        term_pend_q <= stage_i.term_vld;
      end
      if (take_span || take_term) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      info_q <= stage_i;
    end
    if (take_span) begin
      out_q <= span_rsp;
    end else if (take_term) begin
      out_q <= term_rsp;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  span_first_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (span_pend_q && term_pend_q && !oreg_free) |=> (span_pend_q && term_pend_q))
    else $error("pending results dropped while output stalled");

  no_load_over_pending_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !(span_pend_q && term_pend_q))
    else $error("request loaded over two pending results");

  term_fields_zero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.kind != brle_pkg::KIND_SPAN) |-> (out_q.span_len == 8'd0))
    else $error("status result carries span fields");

endmodule

### hw/rtl/bmp_rle_pixel_decoder_core.sv
// An accepted request's stage info and palette read are registered, then each result
// is registered in the output register; a second result (span then status) follows
// the first. Throughput: one request per cycle while the output is not stalled; a
// request with two results holds input until its span is taken.
// Reset clears parse state, config registers and the output stage; the palette
// memory is not cleared and must be written before its entries are used.
module bmp_rle_pixel_decoder_core #(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned COORD_BITS    = 16,
  parameter int unsigned OVERRUN_SLACK = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  brle_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output brle_pkg::out_rsp_t out_rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);

  brle_pkg::cfg_t   cfg_q;
  brle_pkg::stage_t stage;
  logic             accept;
  logic             stage_ready;
  logic             pal_we;
  logic [AW-1:0]    pal_waddr;
  logic [31:0]      pal_wdata;
  logic             pal_re;
  logic [AW-1:0]    pal_raddr_a;
  logic [AW-1:0]    pal_raddr_b;
  logic [31:0]      pal_rdata_a;
  logic [31:0]      pal_rdata_b;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = stage_ready;
  assign accept      = in_valid_i && stage_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rle4_mode     <= 1'b0;
      cfg_q.image_width   <= 16'd1;
      cfg_q.image_height  <= 16'd1;
      cfg_q.top_down      <= 1'b0;
      cfg_q.palette_count <= 9'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        brle_pkg::CFG_RLE4_MODE:     cfg_q.rle4_mode     <= cfg_data_i[0];
        brle_pkg::CFG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data_i;
        brle_pkg::CFG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data_i;
        brle_pkg::CFG_TOP_DOWN:      cfg_q.top_down      <= cfg_data_i[0];
        brle_pkg::CFG_PALETTE_COUNT: cfg_q.palette_count <= cfg_data_i[8:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  brle_parser #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .COORD_BITS   (COORD_BITS),
    .OVERRUN_SLACK(OVERRUN_SLACK),
    .AW           (AW)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_i        (in_req_i),
    .cfg_i        (cfg_q),
    .stage_o      (stage),
    .pal_we_o     (pal_we),
    .pal_waddr_o  (pal_waddr),
    .pal_wdata_o  (pal_wdata),
    .pal_re_o     (pal_re),
    .pal_raddr_a_o(pal_raddr_a),
    .pal_raddr_b_o(pal_raddr_b)
  );

  brle_palette_ram #(
    .DEPTH(PALETTE_DEPTH),
    .AW   (AW)
  ) u_palette (
    .clk_i    (clk_i),
    .we_i     (pal_we),
    .waddr_i  (pal_waddr),
    .wdata_i  (pal_wdata),
    .re_i     (pal_re),
    .raddr_a_i(pal_raddr_a),
    .raddr_b_i(pal_raddr_b),
    .rdata_a_o(pal_rdata_a),
    .rdata_b_o(pal_rdata_b)
  );

  brle_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .stage_i    (stage),
    .rdata_a_i  (pal_rdata_a),
    .rdata_b_i  (pal_rdata_b),
    .ready_o    (stage_ready),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule
